@@ design/pits_pkg.sv @@
// Shared constants, request struct and index helpers for the permutation swap table.
package pits_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);
   localparam int DATA_W     = 8;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SWAP   = 2'd1;
   localparam logic [1:0] OP_TOGGLE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   function automatic logic in_range(input logic [DATA_W-1:0] x);
      return (32'(x) < TABLE_SIZE);
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [DATA_W-1:0] x);
      return ADDR_W'(x);
   endfunction

endpackage

@@ design/permutation_inverse_swap_table.sv @@
// Load and toggle act in the idle state; a read passes through S_RD_DATA to the response register.
// Throughput: one request at a time; a swap occupies the sequencer for its 6 steps
// (two reads and two writes of the view table, then two dependent writes of the other).
// Both tables sit in one-write, one-read RAMs with registered read data.
// Synchronous reset sets the values view and clears the response valid; table contents are undefined.
module permutation_inverse_swap_table (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_first_index,
   input  logic [7:0] req_second_index,
   input  logic [7:0] req_load_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_entry_value,
   output logic       rsp_showing_positions
);

   pits_pkg::ram_req_type             val_req, pos_req;
   logic [pits_pkg::DATA_W-1:0]       val_rdata, pos_rdata;

   pits_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_first_index       (req_first_index),
      .req_second_index      (req_second_index),
      .req_load_value        (req_load_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_entry_value       (rsp_entry_value),
      .rsp_showing_positions (rsp_showing_positions),
      .val_req               (val_req),
      .pos_req               (pos_req),
      .val_rdata             (val_rdata),
      .pos_rdata             (pos_rdata)
   );

   pits_ram #(
      .AW    (pits_pkg::ADDR_W),
      .DW    (pits_pkg::DATA_W),
      .DEPTH (pits_pkg::TABLE_SIZE)
   ) u_value_ram (
      .clock (clock),
      .we    (val_req.we),
      .waddr (val_req.waddr),
      .wdata (val_req.wdata),
      .raddr (val_req.raddr),
      .rdata (val_rdata)
   );

   pits_ram #(
      .AW    (pits_pkg::ADDR_W),
      .DW    (pits_pkg::DATA_W),
      .DEPTH (pits_pkg::TABLE_SIZE)
   ) u_position_ram (
      .clock (clock),
      .we    (pos_req.we),
      .waddr (pos_req.waddr),
      .wdata (pos_req.wdata),
      .raddr (pos_req.raddr),
      .rdata (pos_rdata)
   );

endmodule

@@ design/pits_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module pits_ram #(
   parameter int AW    = 8,
   parameter int DW    = 8,
   parameter int DEPTH = 256
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/pits_ctrl.sv @@
// Sequencer: decodes requests and runs read-modify-write on the two tables.
module pits_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic [7:0]                req_first_index,
   input  logic [7:0]                req_second_index,
   input  logic [7:0]                req_load_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_entry_value,
   output logic                      rsp_showing_positions,
   output pits_pkg::ram_req_type     val_req,
   output pits_pkg::ram_req_type     pos_req,
   input  logic [pits_pkg::DATA_W-1:0] val_rdata,
   input  logic [pits_pkg::DATA_W-1:0] pos_rdata
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_RD_DATA = 3'd1;
   localparam logic [2:0] S_SW_RJ   = 3'd2;
   localparam logic [2:0] S_SW_WI   = 3'd3;
   localparam logic [2:0] S_SW_WJ   = 3'd4;
   localparam logic [2:0] S_SW_WX   = 3'd5;
   localparam logic [2:0] S_SW_WY   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       view_ff, view_in;        // 1: values view
   logic [7:0] i_ff, i_in;
   logic [7:0] j_ff, j_in;
   logic [7:0] a_ff, a_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] ox_ff, ox_in;
   logic       ok_ff, ok_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_value_ff, rsp_value_in;
   logic       rsp_pos_ff, rsp_pos_in;

   pits_pkg::ram_req_type view_req, other_req;
   logic [7:0] view_rdata, other_rdata;
   logic       load_we;

   assign view_rdata  = view_ff ? val_rdata : pos_rdata;
   assign other_rdata = view_ff ? pos_rdata : val_rdata;
   assign req_stall   = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      view_in      = view_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      x_in         = x_ff;
      ox_in        = ox_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      view_req     = '0;
      other_req    = '0;
      load_we      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               i_in = req_first_index;
               j_in = req_second_index;
               case (req_operation)
                  pits_pkg::OP_LOAD: begin
                     load_we = pits_pkg::in_range(req_first_index) &&
                               pits_pkg::in_range(req_load_value);
                  end
                  pits_pkg::OP_SWAP: begin
                     if (pits_pkg::in_range(req_first_index) &&
                         pits_pkg::in_range(req_second_index)) begin
                        view_req.raddr = pits_pkg::addr_of(req_first_index);
                        state_in       = S_SW_RJ;
                     end
                  end
                  pits_pkg::OP_TOGGLE: begin
                     view_in = !view_ff;
                  end
                  pits_pkg::OP_READ: begin
                     view_req.raddr = pits_pkg::addr_of(req_first_index);
                     state_in       = S_RD_DATA;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RD_DATA: begin
            view_req.raddr = pits_pkg::addr_of(i_ff);
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pits_pkg::in_range(i_ff) ? view_rdata : 8'd0;
               rsp_pos_in   = !view_ff;
               state_in     = S_IDLE;
            end
         end
         S_SW_RJ: begin
            view_req.raddr = pits_pkg::addr_of(j_ff);
            a_in           = view_rdata;
            state_in       = S_SW_WI;
         end
         S_SW_WI: begin
            view_req.we     = 1'b1;
            view_req.waddr  = pits_pkg::addr_of(i_ff);
            view_req.wdata  = view_rdata;
            other_req.raddr = pits_pkg::addr_of(view_rdata);
            x_in            = view_rdata;
            ok_in           = pits_pkg::in_range(view_rdata) && pits_pkg::in_range(a_ff);
            state_in        = S_SW_WJ;
         end
         S_SW_WJ: begin
            view_req.we     = 1'b1;
            view_req.waddr  = pits_pkg::addr_of(j_ff);
            view_req.wdata  = a_ff;
            other_req.raddr = pits_pkg::addr_of(a_ff);
            ox_in           = other_rdata;
            state_in        = S_SW_WX;
         end
         S_SW_WX: begin
            other_req.we    = ok_ff;
            other_req.waddr = pits_pkg::addr_of(x_ff);
            other_req.wdata = other_rdata;
            state_in        = S_SW_WY;
         end
         S_SW_WY: begin
            other_req.we    = ok_ff;
            other_req.waddr = pits_pkg::addr_of(a_ff);
            other_req.wdata = ox_ff;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      val_req = view_ff ? view_req : other_req;
      pos_req = view_ff ? other_req : view_req;
      if (load_we) begin
         val_req.we    = 1'b1;
         val_req.waddr = pits_pkg::addr_of(req_first_index);
         val_req.wdata = req_load_value;
         pos_req.we    = 1'b1;
         pos_req.waddr = pits_pkg::addr_of(req_load_value);
         pos_req.wdata = req_first_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         view_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         view_ff      <= view_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      a_ff         <= a_in;
      x_ff         <= x_in;
      ox_ff        <= ox_in;
      ok_ff        <= ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_entry_value       = rsp_value_ff;
   assign rsp_showing_positions = rsp_pos_ff;

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RD_DATA)
      else $error("response raised outside read completion");

   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SW_WY |-> $past(state_ff) == S_SW_WX)
      else $error("swap write-back out of order");

   a_view_toggle: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && view_ff != $past(view_ff)) |->
         $past(req_valid && !req_stall && req_operation == pits_pkg::OP_TOGGLE))
      else $error("view changed without toggle request");

   a_no_dual_view_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !load_we)
      else $error("load write while sequencer busy");

endmodule
